// ===== rtl/bia_pkg.sv =====
// Shared types, codes and default sizes of the bitmap ID allocator.
`timescale 1ns / 1ps

package bia_pkg;

    // Default geometry of the bitmap.
    localparam int DEF_WORDS     = 16;
    localparam int DEF_WORD_BITS = 64;

    // Fixed field widths.
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // Reset values of the range registers.
    localparam logic [ID_W-1:0] MIN_ID_RESET = 32'd0;
    localparam logic [ID_W-1:0] MAX_ID_RESET = 32'd1023;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID = 1'b1;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID   = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_CLEAR,
        S_ALLOC_START,
        S_ALLOC_SCAN,
        S_FREE_CHECK,
        S_FREE_SEEK,
        S_FREE_MOD
    } state_t;

endpackage

// ===== rtl/bia_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
// Top level of the bitmap ID allocator: sequencer, range registers and bitmap RAM.
`timescale 1ns / 1ps

// The block hands out and takes back integer IDs between min_id and max_id,
// keeping one bit per ID in a RAM of WORDS words of WORD_BITS bits. A request
// with kind 0 allocates: the words are read round-robin starting at the word
// of the last successful allocation, one word per cycle, and the lowest free
// bit of the first word that has one is claimed; the scan rate is set by the
// single read port of the bitmap RAM. A request with kind 1 frees an ID: after
// a range check, the target word is located by stepping a running offset by
// WORD_BITS through the words up to and including it (so no divider is
// needed), and then that word is read, modified and written back. The block
// takes one transaction at a time and holds in_stall high while it works; a
// finished result sits in the output register while the next transaction is
// accepted. After reset and after every configuration write the block
// rebuilds its range and clears the bitmap in a pass over all words, during
// which no transaction is accepted; configuration writes are always accepted
// and restart that pass. Configuration should only be written while no request
// is in flight.
module bitmap_id_allocator
    import bia_pkg::*;
#(
    parameter int WORDS     = DEF_WORDS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // Request channel.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [ID_W-1:0]      id,

    // Result channel.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [ID_W-1:0]      alloc_id,

    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data
);

    // Derived sizes. CAP is the largest number of IDs the bitmap can hold.
    localparam int CAP    = WORDS * WORD_BITS;
    localparam int SPAN_W = $clog2(CAP + 1);
    localparam int BASE_W = $clog2(CAP + WORD_BITS + 1);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = $clog2(WORDS + 1);

    localparam logic [BASE_W-1:0] WB_STEP  = BASE_W'(WORD_BITS);
    localparam logic [ID_W:0]     CAP_WIDE = (ID_W + 1)'(CAP);

    // Index of the single set bit of a one-hot word.
    function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_BITS-1:0] onehot);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (onehot[b])
            begin
                idx = idx | BIT_W'(b);
            end
        end
        return idx;
    endfunction

    // Sequencer and datapath registers.
    state_t              state_reg, state_next;
    logic [ID_W-1:0]     min_id_reg, min_id_next;
    logic [ID_W-1:0]     max_id_reg, max_id_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [WA_W-1:0]     cursor_reg, cursor_next;
    logic [WA_W-1:0]     word_reg, word_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]    iss_cnt_reg, iss_cnt_next;
    logic                kind_reg, kind_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [SPAN_W-1:0]   off_reg, off_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     alloc_id_reg, alloc_id_next;

    // RAM port signals.
    logic                 ram_wr_en;
    logic [WA_W-1:0]      ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [WA_W-1:0]      ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    // Shared datapath terms.
    logic                 can_emit;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_free;
    logic [CNT_W-1:0]     word_inc;
    logic [WA_W-1:0]      word_wrap;
    logic [BASE_W-1:0]    span_ext;
    logic [BASE_W-1:0]    off_ext;
    logic [BASE_W-1:0]    base_end;
    logic [BASE_W-1:0]    span_rem;
    logic [ID_W:0]        span_wide;
    logic [ID_W-1:0]      id_off;
    logic                 id_in_range;
    logic [ID_W-1:0]      grab_id;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .ADDR_W(WA_W)
    ) u_map_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // The output register can take a new result when it is empty or being drained.
    assign can_emit = !out_valid_reg || !out_stall;

    // Lowest free bit of the word on the RAM read port, isolated as a one-hot mask.
    assign free_bits = ~ram_rd_data;
    assign low_free  = free_bits & (~free_bits + WORD_BITS'(1));

    // Round-robin successor of the current word within the active words.
    assign word_inc  = CNT_W'(word_reg) + CNT_W'(1);
    assign word_wrap = (word_inc == active_reg) ? '0 : word_inc[WA_W-1:0];

    assign span_ext = BASE_W'(span_reg);
    assign off_ext  = BASE_W'(off_reg);
    assign base_end = base_reg + WB_STEP;
    assign span_rem = span_ext - base_reg;

    // Number of IDs in the configured range, clipped to the bitmap capacity.
    always_comb
    begin
        span_wide = {1'b0, max_id_reg} - {1'b0, min_id_reg} + (ID_W + 1)'(1);
        if (min_id_reg > max_id_reg)
        begin
            span_wide = '0;
        end
        else if (span_wide > CAP_WIDE)
        begin
            span_wide = CAP_WIDE;
        end
    end

    // Range check of a freed ID.
    assign id_off      = id_reg - min_id_reg;
    assign id_in_range = (id_reg >= min_id_reg) && (id_reg <= max_id_reg)
                         && (id_off < ID_W'(span_reg));

    assign grab_id = min_id_reg + ID_W'(word_reg) * ID_W'(WORD_BITS)
                     + ID_W'(onehot_index(low_free));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CALC;
            min_id_reg    <= MIN_ID_RESET;
            max_id_reg    <= MAX_ID_RESET;
            span_reg      <= '0;
            active_reg    <= '0;
            cursor_reg    <= '0;
            word_reg      <= '0;
            base_reg      <= '0;
            iss_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_id_reg    <= min_id_next;
            max_id_reg    <= max_id_next;
            span_reg      <= span_next;
            active_reg    <= active_next;
            cursor_reg    <= cursor_next;
            word_reg      <= word_next;
            base_reg      <= base_next;
            iss_cnt_reg   <= iss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        off_reg      <= off_next;
        bit_reg      <= bit_next;
        status_reg   <= status_next;
        alloc_id_reg <= alloc_id_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        min_id_next    = min_id_reg;
        max_id_next    = max_id_reg;
        span_next      = span_reg;
        active_next    = active_reg;
        cursor_next    = cursor_reg;
        word_next      = word_reg;
        base_next      = base_reg;
        iss_cnt_next   = iss_cnt_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        off_next       = off_reg;
        bit_next       = bit_reg;
        status_next    = status_reg;
        alloc_id_next  = alloc_id_reg;
        out_valid_next = out_valid_reg && out_stall;

        ram_wr_en   = 1'b0;
        ram_wr_addr = word_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    id_next    = id;
                    state_next = (kind == KIND_ALLOC) ? S_ALLOC_START : S_FREE_CHECK;
                end
            end

            // Latch the clipped span and start the clearing pass.
            S_CALC:
            begin
                span_next   = span_wide[SPAN_W-1:0];
                active_next = '0;
                cursor_next = '0;
                word_next   = '0;
                base_next   = '0;
                state_next  = S_CLEAR;
            end

            // One word per cycle: words fully inside or past the range are cleared, the
            // last partial word gets its bits past the range marked as used.
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = word_reg;
                if (span_ext >= base_end)
                begin
                    ram_wr_data = '0;
                end
                else if (span_ext > base_reg)
                begin
                    ram_wr_data = {WORD_BITS{1'b1}} << span_rem[BIT_W-1:0];
                end
                else
                begin
                    ram_wr_data = '0;
                end
                if (span_ext > base_reg)
                begin
                    active_next = active_reg + CNT_W'(1);
                end
                base_next = base_end;
                word_next = word_reg + WA_W'(1);
                if (word_reg == WA_W'(WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
            end

            S_ALLOC_START:
            begin
                if (active_reg == '0)
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_NO_SPACE;
                        alloc_id_next  = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = cursor_reg;
                    word_next    = cursor_reg;
                    iss_cnt_next = CNT_W'(1);
                    state_next   = S_ALLOC_SCAN;
                end
            end

            // The word on the read port is examined; if it is full, the next one is fetched in the same cycle.
            S_ALLOC_SCAN:
            begin
                if (free_bits != '0)
                begin
                    if (can_emit)
                    begin
                        ram_wr_en      = 1'b1;
                        ram_wr_addr    = word_reg;
                        ram_wr_data    = ram_rd_data | low_free;
                        cursor_next    = word_reg;
                        out_valid_next = 1'b1;
                        status_next    = STATUS_OK;
                        alloc_id_next  = grab_id;
                        state_next     = S_IDLE;
                    end
                end
                else if (iss_cnt_reg == active_reg)
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_NO_SPACE;
                        alloc_id_next  = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = word_wrap;
                    word_next    = word_wrap;
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                end
            end

            S_FREE_CHECK:
            begin
                if (id_in_range)
                begin
                    off_next   = id_off[SPAN_W-1:0];
                    word_next  = '0;
                    base_next  = '0;
                    state_next = S_FREE_SEEK;
                end
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_BAD_ID;
                    alloc_id_next  = '0;
                    state_next     = S_IDLE;
                end
            end

            // Step the word base until it covers the offset, then fetch that word.
            S_FREE_SEEK:
            begin
                if (off_ext < base_end)
                begin
                    bit_next    = BIT_W'(off_ext - base_reg);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = word_reg;
                    state_next  = S_FREE_MOD;
                end
                else
                begin
                    word_next = word_reg + WA_W'(1);
                    base_next = base_end;
                end
            end

            S_FREE_MOD:
            begin
                if (can_emit)
                begin
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = word_reg;
                    ram_wr_data    = ram_rd_data & ~(WORD_BITS'(1) << bit_reg);
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    alloc_id_next  = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A register write rebuilds the range and restarts the clearing pass.
        if (cfg_valid)
        begin
            priority if (cfg_index == CFG_MIN_ID)
            begin
                min_id_next = cfg_data;
            end
            else if (cfg_index == CFG_MAX_ID)
            begin
                max_id_next = cfg_data;
            end
            state_next = S_CALC;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign alloc_id  = alloc_id_reg;

endmodule

// ===== dv/bitmap_id_allocator_checker.sv =====
// Checker for the bitmap ID allocator: tracks the ID bitmap and compares every result.
`timescale 1ns / 1ps

module bitmap_id_allocator_checker
    import bia_pkg::*;
#(
    parameter int WORDS     = DEF_WORDS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 kind,
    input  logic [ID_W-1:0]      id,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [STATUS_W-1:0]  status,
    input  logic [ID_W-1:0]      alloc_id,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     alloc_id;
    } answer_t;

    logic [WORD_BITS-1:0] used_map [WORDS];
    int unsigned          cursor_word;
    int unsigned          active_words;
    longint unsigned      span_ids;
    logic [ID_W-1:0]      lo_id;
    logic [ID_W-1:0]      hi_id;
    answer_t              due_answers [$];
    int                   fail_tally;

    // Clears the bitmap and cursor and marks the tail of the last active word as used.
    function automatic void rebuild_map();
        longint unsigned cap;
        int unsigned     rem;
        cap = 64'(WORDS) * 64'(WORD_BITS);
        for (int w = 0; w < WORDS; w++)
            used_map[w] = '0;
        cursor_word = 0;
        span_ids = (lo_id > hi_id) ? 64'd0 : 64'(hi_id) - 64'(lo_id) + 64'd1;
        if (span_ids > cap)
            span_ids = cap;
        active_words = int'((span_ids + WORD_BITS - 1) / WORD_BITS);
        rem = int'(span_ids % WORD_BITS);
        if (active_words > 0 && rem != 0)
            for (int b = rem; b < WORD_BITS; b++)
                used_map[active_words-1][b] = 1'b1;
    endfunction

    // Next-fit search starting at the cursor word.
    function automatic answer_t grant_next();
        answer_t     ans;
        int unsigned w;
        ans.status   = STATUS_NO_SPACE;
        ans.alloc_id = '0;
        for (int unsigned i = 0; i < active_words; i++) begin
            w = (cursor_word + i) % active_words;
            if (&used_map[w])
                continue;
            for (int b = 0; b < WORD_BITS; b++) begin
                if (!used_map[w][b]) begin
                    used_map[w][b] = 1'b1;
                    cursor_word    = w;
                    ans.status     = STATUS_OK;
                    ans.alloc_id   = ID_W'(64'(lo_id) + 64'(w) * 64'(WORD_BITS) + 64'(b));
                    return ans;
                end
            end
        end
        return ans;
    endfunction

    function automatic answer_t release_id(input logic [ID_W-1:0] rid);
        answer_t         ans;
        longint unsigned off;
        ans.status   = STATUS_BAD_ID;
        ans.alloc_id = '0;
        if (rid < lo_id || rid > hi_id)
            return ans;
        off = 64'(rid) - 64'(lo_id);
        if (off >= span_ids)
            return ans;
        used_map[off / WORD_BITS][off % WORD_BITS] = 1'b0;
        ans.status = STATUS_OK;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            lo_id = MIN_ID_RESET;
            hi_id = MAX_ID_RESET;
            rebuild_map();
            due_answers.delete();
            fail_tally = 0;
        end
        else
        begin
            // Results leave before a new transaction is taken in the same cycle.
            if (out_valid && !out_stall)
            begin
                if (due_answers.size() == 0)
                begin
                    $error("unexpected result: status %0d, alloc_id 0x%08h", status, alloc_id);
                    fail_tally++;
                end
                else
                begin
                    want = due_answers.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_tally++;
                    end
                    if (alloc_id !== want.alloc_id)
                    begin
                        $error("alloc_id: expected 0x%08h, actual 0x%08h",
                               want.alloc_id, alloc_id);
                        fail_tally++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIN_ID)
                    lo_id = cfg_data;
                else if (cfg_index == CFG_MAX_ID)
                    hi_id = cfg_data;
                rebuild_map();
            end
            if (in_valid && !in_stall)
                due_answers.push_back((kind == KIND_ALLOC) ? grant_next() : release_id(id));
        end
        mismatches  <= fail_tally;
        outstanding <= due_answers.size();
    end

endmodule

// ===== dv/bitmap_id_allocator_tb.sv =====
// Top of the bitmap ID allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The bench drives allocate and free requests into the allocator and leaves
// all prediction and comparison to the checker beside it. The run opens with
// a short directed sequence (range edges, a repeated free, an empty range, a
// range at the top of the ID space and a range wider than the bitmap), then
// walks through a series of segments. Each segment programs a fresh range
// while the block is idle and sends a burst of requests: mostly allocates and
// frees of IDs inside the range, so the bitmap fills up and the cursor wraps,
// plus some frees outside the range. The idle pattern changes every third of
// the segments: first the result taker is the lazy side, then the requester,
// and last neither side idles.
module bitmap_id_allocator_tb;
    import bia_pkg::*;

    localparam int WORDS       = DEF_WORDS;
    localparam int WORD_BITS   = DEF_WORD_BITS;
    localparam int CAPACITY    = WORDS * WORD_BITS;
    localparam int SEGMENTS    = 12;
    localparam int STALL_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 kind;
    logic [ID_W-1:0]      id;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      alloc_id;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ID_W-1:0]      cfg_data;

    int mismatches;
    int outstanding;
    int idle_cycles;

    // Idle percentages of the two sides, changed between segments.
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    // The range currently programmed, kept here only to aim the free requests.
    logic [ID_W-1:0] range_lo;
    logic [ID_W-1:0] range_hi;
    longint unsigned range_span;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    bitmap_id_allocator #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .id        (id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .alloc_id  (alloc_id),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bitmap_id_allocator_checker #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) i_id_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .id          (id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .alloc_id    (alloc_id),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // The result taker stalls at random with the current percentage.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    // Watchdog: a long run of cycles with no transaction on any channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("bitmap_id_allocator_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Sends one request, possibly after a short idle gap, and returns at the
    // edge where the transaction is taken. The payload stays put while stalled.
    task automatic send_item(input logic k, input logic [ID_W-1:0] v);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        id       <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Holds the requester off until every result has come back. The first
    // edge lets the count catch up with a transaction taken on the last edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Writes both range registers back to back; valid stays high between them.
    task automatic set_range(input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MIN_ID;
        cfg_data  <= lo;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_MAX_ID;
        cfg_data  <= hi;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        range_lo   = lo;
        range_hi   = hi;
        range_span = (lo > hi) ? 64'd0 : 64'(hi) - 64'(lo) + 64'd1;
        if (range_span > 64'(CAPACITY))
            range_span = 64'(CAPACITY);
    endtask

    initial
    begin
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        int unsigned     span;
        int unsigned     roll;
        int unsigned     alloc_pct;
        int              burst;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        kind       <= KIND_ALLOC;
        id         <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_MIN_ID;
        cfg_data   <= '0;
        tx_idle_pct = 21;
        rx_idle_pct = 68;
        range_lo    = MIN_ID_RESET;
        range_hi    = MAX_ID_RESET;
        range_span  = 64'(MAX_ID_RESET) - 64'(MIN_ID_RESET) + 64'd1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset range 0..1023: the first allocations count up from zero, the
        // payload ID of an allocate is ignored, a free of an already free ID
        // still succeeds, and the first IDs past either end are refused.
        send_item(KIND_ALLOC, '0);
        send_item(KIND_ALLOC, '1);
        send_item(KIND_ALLOC, '0);
        send_item(KIND_FREE, 32'd0);
        send_item(KIND_FREE, 32'd0);
        send_item(KIND_FREE, 32'd1023);
        send_item(KIND_FREE, 32'd1024);
        send_item(KIND_FREE, '1);
        send_item(KIND_ALLOC, '0);

        // Inverted range: nothing to hand out and nothing to free.
        wait_drained();
        set_range(32'd5, 32'd4);
        send_item(KIND_ALLOC, '0);
        send_item(KIND_FREE, 32'd5);
        send_item(KIND_FREE, 32'd4);

        // Three IDs at the very top of the ID space: fill, run dry, free the
        // last one and get it back.
        wait_drained();
        set_range(32'hFFFF_FFFD, 32'hFFFF_FFFF);
        repeat (4) send_item(KIND_ALLOC, '0);
        send_item(KIND_FREE, 32'hFFFF_FFFF);
        send_item(KIND_ALLOC, '0);

        // A range wider than the bitmap is clipped, so IDs past the clipped
        // span are refused even though they lie within min_id..max_id.
        wait_drained();
        set_range(32'd0, 32'hFFFF_FFFF);
        send_item(KIND_FREE, CAPACITY);
        send_item(KIND_FREE, 32'hFFFF_FFFF);
        send_item(KIND_FREE, CAPACITY - 1);
        send_item(KIND_ALLOC, '0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 4)
                0:
                begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 68;
                end
                1:
                begin
                    tx_idle_pct = 68;
                    rx_idle_pct = 21;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            // Reprogram only once the block has nothing in flight.
            wait_drained();
            burst = 110;
            case (seg % 6)
                0:
                begin
                    // A small range inside one word, filled quickly.
                    span = $urandom_range(1, WORD_BITS);
                    lo   = $urandom_range(0, 32'hFFFF_0000);
                    hi   = lo + span - 1;
                end
                1:
                begin
                    // The full ID space, clipped to the bitmap size.
                    lo = '0;
                    hi = '1;
                end
                2:
                begin
                    // Several words with a partly used last word.
                    span = $urandom_range(WORD_BITS + 1, 5 * WORD_BITS - 1);
                    lo   = $urandom_range(0, 32'hFFFF_0000);
                    hi   = lo + span - 1;
                end
                3:
                begin
                    // Range that ends at the largest ID.
                    hi = '1;
                    lo = hi - $urandom_range(0, 150);
                end
                4:
                begin
                    // Empty range; the second time at the widest inversion.
                    if (seg < 6)
                    begin
                        hi = $urandom_range(0, 32'hFFFF_0000);
                        lo = hi + $urandom_range(1, 1000);
                    end
                    else
                    begin
                        lo = '1;
                        hi = '0;
                    end
                    burst = 30;
                end
                default:
                begin
                    // Whole words only, no tail to mask off.
                    span = WORD_BITS * $urandom_range(1, WORDS);
                    lo   = $urandom_range(0, 32'hFFFF_0000);
                    hi   = lo + span - 1;
                end
            endcase
            set_range(lo, hi);

            // Mostly allocates against frees aimed inside the range, so the
            // bitmap fills and frees punch holes for next-fit to find; the rest
            // are frees just outside the range or anywhere at all.
            alloc_pct = $urandom_range(45, 85);
            repeat (burst)
            begin
                roll = $urandom_range(0, 99);
                if (roll < alloc_pct)
                    send_item(KIND_ALLOC, $urandom);
                else if (roll < 92 && range_span != 0)
                    send_item(KIND_FREE,
                              range_lo + $urandom_range(0, 32'(range_span - 64'd1)));
                else
                begin
                    case ($urandom_range(0, 3))
                        0: send_item(KIND_FREE, $urandom);
                        1: send_item(KIND_FREE, range_lo - 1);
                        2: send_item(KIND_FREE, range_hi + 1);
                        default: send_item(KIND_FREE, range_lo + CAPACITY);
                    endcase
                end
            end
        end

        wait_drained();
        repeat (WORDS + 4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("bitmap_id_allocator_tb: done, clean");
        else
            $display("bitmap_id_allocator_tb: done, errors");
        $finish;
    end

endmodule
